[design/ptl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_pkg: shared types and codes
// Word formats, action and status codes and the decoded operation passed
// from the front end to the execution back end.
// ----------------------------------------------------------------------------
package ptl_pkg;

    localparam int FIELD_W   = 16;
    localparam int POS_W     = 7;
    localparam int ACT_W     = 3;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;
    localparam int QDEPTH    = 2;

    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEC_L  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEC_P  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        K_NONE,
        K_APPEND,
        K_DELETE,
        K_READ,
        K_WRITE,
        K_DEC_L,
        K_DEC_P
    } t_kind;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic [POS_W-1:0]          position;
        logic signed [FIELD_W-1:0] p_value;
        logic signed [FIELD_W-1:0] l_value;
        logic signed [FIELD_W-1:0] n_value;
    } t_in_word;

    typedef struct packed {
        logic signed [FIELD_W-1:0] p_out;
        logic signed [FIELD_W-1:0] l_out;
        logic signed [FIELD_W-1:0] n_out;
        logic [STAT_W-1:0]         status;
        logic [CNT_OUT_W-1:0]      count_out;
    } t_out_word;

    typedef struct packed {
        t_kind                     kind;
        logic [POS_W-1:0]          idx;
        logic signed [FIELD_W-1:0] p_value;
        logic signed [FIELD_W-1:0] l_value;
        logic signed [FIELD_W-1:0] n_value;
        logic [STAT_W-1:0]         status;
        logic [CNT_OUT_W-1:0]      count_out;
    } t_op;

endpackage

[design/ptl_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_chan_if: valid/ready channel
// One word moves at each clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ptl_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/ptl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_front: command decode
// Tracks the entry count as seen by accepted words, range-checks positions
// and emits a decoded operation with its final status and count.
// ----------------------------------------------------------------------------
module ptl_front #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptl_chan_if.sink    i_cmd,
    ptl_chan_if.source  o_push
);
    import ptl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [POS_W-1:0] w_pos;
    logic [XW-1:0]    w_pos_x;
    logic [XW-1:0]    w_cnt_x;
    logic             w_in_range;
    logic             w_full;
    t_op              w_op;

    assign w_pos      = i_cmd.payload.position;
    assign w_pos_x    = XW'(w_pos);
    assign w_cnt_x    = XW'(r_count);
    assign w_in_range = (w_pos != '0) && (w_pos_x <= w_cnt_x);
    assign w_full     = (r_count == CW'(DEPTH));

    always_comb begin
        n_count        = r_count;
        w_op.kind      = K_NONE;
        w_op.idx       = w_in_range ? (w_pos - POS_W'(1)) : '0;
        w_op.p_value   = i_cmd.payload.p_value;
        w_op.l_value   = i_cmd.payload.l_value;
        w_op.n_value   = i_cmd.payload.n_value;
        w_op.status    = STAT_DONE;
        case (i_cmd.payload.action)
            ACT_APPEND: begin
                if (w_full) begin
                    w_op.status = STAT_FULL;
                end else begin
                    w_op.kind = K_APPEND;
                    n_count   = r_count + CW'(1);
                end
            end
            ACT_DELETE: begin
                if (!w_in_range) begin
                    w_op.status = STAT_RANGE;
                end else begin
                    w_op.kind = K_DELETE;
                    n_count   = r_count - CW'(1);
                end
            end
            ACT_READ: begin
                if (!w_in_range) w_op.status = STAT_RANGE;
                else             w_op.kind   = K_READ;
            end
            ACT_WRITE: begin
                if (!w_in_range) w_op.status = STAT_RANGE;
                else             w_op.kind   = K_WRITE;
            end
            ACT_DEC_L: begin
                if (!w_in_range) w_op.status = STAT_RANGE;
                else             w_op.kind   = K_DEC_L;
            end
            ACT_DEC_P: begin
                if (!w_in_range) w_op.status = STAT_RANGE;
                else             w_op.kind   = K_DEC_P;
            end
            default: begin
                w_op.kind = K_NONE;
            end
        endcase
        w_op.count_out = CNT_OUT_W'(n_count);
    end

    assign o_push.valid   = i_cmd.valid;
    assign o_push.payload = w_op;
    assign i_cmd.ready    = o_push.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_count <= n_count;
        end
    end

endmodule

[design/ptl_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_queue: operation queue
// Small FIFO of decoded operations between the front end and back end.
// ----------------------------------------------------------------------------
module ptl_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptl_chan_if.sink    i_push,
    ptl_chan_if.source  o_pop
);
    import ptl_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int FW = $clog2(QDEPTH + 1);

    t_op           r_slot [QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [FW-1:0] r_fill;
    logic          w_push;
    logic          w_pop;

    assign i_push.ready  = (r_fill != FW'(QDEPTH));
    assign o_pop.valid   = (r_fill != '0);
    assign o_pop.payload = r_slot[r_rp];
    assign w_push        = i_push.valid && i_push.ready;
    assign w_pop         = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_push.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (w_pop)  r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (w_push && !w_pop)      r_fill <= r_fill + FW'(1);
            else if (w_pop && !w_push) r_fill <= r_fill - FW'(1);
        end
    end

endmodule

[design/ptl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_back: entry store and executor
// Holds the entry memory; shifts for delete and suffix decrements run as a
// read-ahead/write-behind sweep, one entry per cycle.
// ----------------------------------------------------------------------------
module ptl_back #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptl_chan_if.sink    i_pop,
    ptl_chan_if.source  o_rsp
);
    import ptl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int VB = VALUE_BITS;
    localparam int EW = 3 * VB;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_rd_addr, n_rd_addr;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;
    logic [CW-1:0]   r_rd_left, n_rd_left;
    logic [CW-1:0]   r_wr_left, n_wr_left;
    logic            r_rsp_valid, n_rsp_valid;
    t_out_word       r_rsp, n_rsp;
    logic [EW-1:0]   r_mem [DEPTH];
    logic [EW-1:0]   r_rdata;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [EW-1:0]   w_wdata;
    logic            w_re;
    logic [AW-1:0]   w_raddr;
    logic [CW-1:0]   w_idx_c;
    logic [AW-1:0]   w_idx_a;
    logic [CW-1:0]   w_span;
    logic [EW-1:0]   w_in_word;
    logic [EW-1:0]   w_scan_data;
    logic            w_slot_free;

    function automatic logic [VB-1:0] to_store(logic signed [FIELD_W-1:0] v);
        return VB'(v);
    endfunction

    function automatic logic signed [FIELD_W-1:0] to_field(logic [VB-1:0] v);
        logic signed [VB-1:0] s;
        s = v;
        return FIELD_W'(s);
    endfunction

    assign w_idx_c     = CW'(i_pop.payload.idx);
    assign w_idx_a     = AW'(i_pop.payload.idx);
    assign w_in_word   = {to_store(i_pop.payload.p_value),
                          to_store(i_pop.payload.l_value),
                          to_store(i_pop.payload.n_value)};
    assign w_slot_free = !r_rsp_valid || o_rsp.ready;

    always_comb begin
        w_scan_data = r_rdata;
        case (r_op.kind)
            K_DEC_L: w_scan_data[2*VB-1:VB]  = r_rdata[2*VB-1:VB] - VB'(1);
            K_DEC_P: w_scan_data[EW-1:2*VB]  = r_rdata[EW-1:2*VB] - VB'(1);
            default: w_scan_data = r_rdata;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_rd_addr   = r_rd_addr;
        n_wr_addr   = r_wr_addr;
        n_rd_left   = r_rd_left;
        n_wr_left   = r_wr_left;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        w_we        = 1'b0;
        w_waddr     = w_idx_a;
        w_wdata     = w_in_word;
        w_re        = 1'b0;
        w_raddr     = w_idx_a;
        w_span      = '0;

        if (r_rsp_valid && o_rsp.ready) n_rsp_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_pop.valid) begin
                    n_op    = i_pop.payload;
                    n_state = S_DONE;
                    case (i_pop.payload.kind)
                        K_APPEND: begin
                            w_we    = 1'b1;
                            w_waddr = AW'(r_count);
                            n_count = r_count + CW'(1);
                        end
                        K_WRITE: begin
                            w_we = 1'b1;
                        end
                        K_READ: begin
                            w_re = 1'b1;
                        end
                        K_DELETE: begin
                            n_count = r_count - CW'(1);
                            w_span  = r_count - w_idx_c - CW'(1);
                            if (w_span != '0) begin
                                w_re      = 1'b1;
                                w_raddr   = w_idx_a + AW'(1);
                                n_rd_addr = w_idx_a + AW'(2);
                                n_rd_left = w_span - CW'(1);
                                n_wr_addr = w_idx_a;
                                n_wr_left = w_span;
                                n_state   = S_SCAN;
                            end
                        end
                        K_DEC_L, K_DEC_P: begin
                            w_span    = r_count - w_idx_c;
                            w_re      = 1'b1;
                            n_rd_addr = w_idx_a + AW'(1);
                            n_rd_left = w_span - CW'(1);
                            n_wr_addr = w_idx_a;
                            n_wr_left = w_span;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_we      = 1'b1;
                w_waddr   = r_wr_addr;
                w_wdata   = w_scan_data;
                n_wr_addr = r_wr_addr + AW'(1);
                n_wr_left = r_wr_left - CW'(1);
                if (r_rd_left != '0) begin
                    w_re      = 1'b1;
                    w_raddr   = r_rd_addr;
                    n_rd_addr = r_rd_addr + AW'(1);
                    n_rd_left = r_rd_left - CW'(1);
                end
                if (r_wr_left == CW'(1)) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_rsp_valid     = 1'b1;
                    n_rsp.status    = r_op.status;
                    n_rsp.count_out = r_op.count_out;
                    if (r_op.kind == K_READ) begin
                        n_rsp.p_out = to_field(r_rdata[EW-1:2*VB]);
                        n_rsp.l_out = to_field(r_rdata[2*VB-1:VB]);
                        n_rsp.n_out = to_field(r_rdata[VB-1:0]);
                    end else begin
                        n_rsp.p_out = '0;
                        n_rsp.l_out = '0;
                        n_rsp.n_out = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_pop.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_re) r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_rd_left <= n_rd_left;
        r_wr_left <= n_wr_left;
        r_rsp     <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_wr_left != '0) && (r_rd_left < r_wr_left))
        else $error("sweep read pointer not ahead of write pointer");

    a_done_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && w_slot_free |=> (r_state == S_IDLE) && r_rsp_valid)
        else $error("finished word not delivered to output register");

    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && (r_op.kind == K_READ) && $past(r_state == S_DONE)
        |-> $stable(r_rdata))
        else $error("read data changed while waiting for output");
`endif

endmodule

[design/positional_triple_list_unit.sv]
`timescale 1ns / 1ps
// Sequencing: a delete at position k moves the count-k entries behind it and a suffix
//   decrement from position k updates count-k+1 entries, one memory entry a cycle.
//   The back end takes a new operation only when idle, after the last one is done,
//   and holds a finished result until the output register is free.
// Reset: synchronous, active low; clears the counts, queue and sequencer. Entry
//   memory is not cleared.
// ----------------------------------------------------------------------------
// positional_triple_list_unit: positional list of (p, l, n) triples
// Front end decode, operation queue and memory back end.
// ----------------------------------------------------------------------------
module positional_triple_list_unit #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptl_chan_if.sink    i_cmd,
    ptl_chan_if.source  o_rsp
);
    import ptl_pkg::*;

    ptl_chan_if #(.t_payload(t_op)) u_q_in ();
    ptl_chan_if #(.t_payload(t_op)) u_q_out ();

    ptl_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_push  (u_q_in)
    );

    ptl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (u_q_in),
        .o_pop   (u_q_out)
    );

    ptl_back #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pop   (u_q_out),
        .o_rsp   (o_rsp)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for positional_triple_list_unit
// Drives action words through the command channel with random gaps and
// checks every response word against a positional list predictor kept in
// the bench. A directed opener is followed by random phases that fill the
// list to full, churn it near full, then drain it to empty. One long
// response stall backs up the unit.
// ----------------------------------------------------------------------------
module tb_top;
    import ptl_pkg::*;

    localparam int DEPTH       = 64;
    localparam int VALUE_BITS  = 16;
    localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;
    localparam int HOLD_AT     = 330;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_WAIT  = 100;

    class list_scoreboard;
        localparam int DEPTH = 64;

        // entry storage at the bench value width (VALUE_BITS == FIELD_W)
        logic signed [FIELD_W-1:0] p_mem [DEPTH];
        logic signed [FIELD_W-1:0] l_mem [DEPTH];
        logic signed [FIELD_W-1:0] n_mem [DEPTH];
        int        count;
        int        errors;
        t_out_word expected_rsp [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function void note_command(t_in_word w);
            t_out_word r;
            bit        hit;
            int        idx;
            r   = '0;
            hit = (w.position >= 1) && (w.position <= count);
            idx = hit ? int'(w.position) - 1 : 0;
            case (w.action)
                ACT_APPEND: begin
                    if (count >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        p_mem[count] = w.p_value;
                        l_mem[count] = w.l_value;
                        n_mem[count] = w.n_value;
                        count++;
                    end
                end
                ACT_DELETE: begin
                    if (!hit) begin
                        r.status = STAT_RANGE;
                    end else begin
                        for (int k = idx; k < count - 1; k++) begin
                            p_mem[k] = p_mem[k+1];
                            l_mem[k] = l_mem[k+1];
                            n_mem[k] = n_mem[k+1];
                        end
                        count--;
                    end
                end
                ACT_READ: begin
                    if (!hit) begin
                        r.status = STAT_RANGE;
                    end else begin
                        r.p_out = p_mem[idx];
                        r.l_out = l_mem[idx];
                        r.n_out = n_mem[idx];
                    end
                end
                ACT_WRITE: begin
                    if (!hit) begin
                        r.status = STAT_RANGE;
                    end else begin
                        p_mem[idx] = w.p_value;
                        l_mem[idx] = w.l_value;
                        n_mem[idx] = w.n_value;
                    end
                end
                ACT_DEC_L: begin
                    if (!hit) begin
                        r.status = STAT_RANGE;
                    end else begin
                        for (int k = idx; k < count; k++) l_mem[k] = l_mem[k] - 1'b1;
                    end
                end
                ACT_DEC_P: begin
                    if (!hit) begin
                        r.status = STAT_RANGE;
                    end else begin
                        for (int k = idx; k < count; k++) p_mem[k] = p_mem[k] - 1'b1;
                    end
                end
                default: ;
            endcase
            r.count_out = CNT_OUT_W'(count);
            expected_rsp.push_back(r);
        endfunction

        function void check_response(t_out_word got);
            t_out_word exp;
            if (expected_rsp.size() == 0) begin
                $error("unexpected response word: status %0d count %0d",
                       got.status, got.count_out);
                errors++;
                return;
            end
            exp = expected_rsp.pop_front();
            if (got.p_out !== exp.p_out) begin
                $error("p_out mismatch: expected %0d, got %0d", exp.p_out, got.p_out);
                errors++;
            end
            if (got.l_out !== exp.l_out) begin
                $error("l_out mismatch: expected %0d, got %0d", exp.l_out, got.l_out);
                errors++;
            end
            if (got.n_out !== exp.n_out) begin
                $error("n_out mismatch: expected %0d, got %0d", exp.n_out, got.n_out);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status mismatch: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.count_out !== exp.count_out) begin
                $error("count_out mismatch: expected %0d, got %0d",
                       exp.count_out, got.count_out);
                errors++;
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   calm;
    int   words_sent;
    int   hold_left;
    bit   hold_done;

    list_scoreboard sb;

    ptl_chan_if #(.t_payload(t_in_word))  cmd_if ();
    ptl_chan_if #(.t_payload(t_out_word)) rsp_if ();

    positional_triple_list_unit #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // response side: random back-pressure plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && words_sent >= HOLD_AT) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            rsp_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
    end

    function automatic t_in_word make_word(logic [ACT_W-1:0] act, int pos,
                                           int pv, int lv, int nv);
        t_in_word w;
        w.action   = act;
        w.position = POS_W'(pos);
        w.p_value  = FIELD_W'(pv);
        w.l_value  = FIELD_W'(lv);
        w.n_value  = FIELD_W'(nv);
        return w;
    endfunction

    function automatic logic signed [FIELD_W-1:0] rand_value();
        case ($urandom_range(15))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic int pick_position();
        if (sb.count == 0 || $urandom_range(9) == 0) begin
            case ($urandom_range(2))
                0:       return 0;
                1:       return sb.count + 1;
                default: return $urandom_range(127);
            endcase
        end
        return $urandom_range(sb.count, 1);
    endfunction

    function automatic t_in_word random_word(int append_pct);
        t_in_word w;
        int       sel;
        w.p_value  = rand_value();
        w.l_value  = rand_value();
        w.n_value  = rand_value();
        w.position = POS_W'(pick_position());
        if ($urandom_range(99) < append_pct) begin
            w.action = ACT_APPEND;
        end else begin
            sel = $urandom_range(19);
            case (sel % 5)
                0:       w.action = ACT_DELETE;
                1:       w.action = ACT_READ;
                2:       w.action = ACT_WRITE;
                3:       w.action = ACT_DEC_L;
                default: w.action = ACT_DEC_P;
            endcase
            if (sel == 0) w.action = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        if (!calm) begin
            while ($urandom_range(99) < 30) begin
                cmd_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= w;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        sb.note_command(w);
        words_sent++;
    endtask

    task automatic run_random(int n_words, int append_pct);
        repeat (n_words) send_word(random_word(append_pct));
    endtask

    initial begin
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        sb             = new();
        words_sent     = 0;
        calm           = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every positional action is out of range
        send_word(make_word(ACT_READ,   1, 0, 0, 0));
        send_word(make_word(ACT_DELETE, 0, 0, 0, 0));
        send_word(make_word(ACT_DEC_L,  1, 0, 0, 0));
        send_word(make_word(ACT_APPEND, 0, 32767, -32768, 0));
        send_word(make_word(ACT_APPEND, 127, -32768, 32767, -1));
        send_word(make_word(ACT_APPEND, 64, 0, -1, 32767));
        send_word(make_word(ACT_READ,   1, 0, 0, 0));
        send_word(make_word(ACT_READ,   2, 0, 0, 0));
        send_word(make_word(ACT_READ,   3, 0, 0, 0));
        send_word(make_word(ACT_READ,   0, 0, 0, 0));
        send_word(make_word(ACT_READ,   4, 0, 0, 0));
        send_word(make_word(ACT_READ,   127, 0, 0, 0));
        send_word(make_word(ACT_WRITE,  3, -1, 0, -32768));
        send_word(make_word(ACT_WRITE,  4, 1, 1, 1));
        // wrap below the minimum on l of entry 1 and p of entry 2
        send_word(make_word(ACT_DEC_L,  1, 0, 0, 0));
        send_word(make_word(ACT_DEC_P,  2, 0, 0, 0));
        send_word(make_word(ACT_READ,   1, 0, 0, 0));
        send_word(make_word(ACT_READ,   2, 0, 0, 0));
        send_word(make_word(ACT_READ,   3, 0, 0, 0));
        send_word(make_word(ACT_SPARE_A, 1, 0, 0, 0));
        send_word(make_word(ACT_SPARE_B, 2, 0, 0, 0));
        send_word(make_word(ACT_DELETE, 3, 0, 0, 0));
        send_word(make_word(ACT_DELETE, 1, 0, 0, 0));
        send_word(make_word(ACT_READ,   1, 0, 0, 0));
        send_word(make_word(ACT_DELETE, 1, 0, 0, 0));

        // grow toward full
        run_random(120, 80);
        while (sb.count < DEPTH) send_word(random_word(100));
        run_random(3, 100);

        // churn near full, no idling on either side
        calm = 1'b1;
        run_random(130, 45);
        calm = 1'b0;

        // drain; the long response hold-off lands here
        run_random(60, 25);
        while (sb.count > 0) send_word(make_word(ACT_DELETE, pick_position(), 0, 0, 0));
        run_random(5, 0);

        cmd_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
